// ===== design/fzy_pkg.sv =====
package fzy_pkg;

   // fixed point of the sensor words
   localparam int FRAC_BITS = 4;
   localparam int ONE       = 1 << FRAC_BITS;

   // field widths
   localparam int TEMP_W  = 12;
   localparam int HUM_W   = 11;
   localparam int NH3_W   = 13;
   localparam int TGT_W   = 10;
   localparam int SPEED_W = 8;
   localparam int SCORE_W = 7;

   localparam logic [TGT_W-1:0] TARGET_RESET = TGT_W'(528);

   // membership degrees, 0..MU_ONE
   localparam int MU_FRAC = 8;
   localparam int MU_ONE  = 1 << MU_FRAC;
   localparam int MU_W    = MU_FRAC + 1;
   localparam int MU_HALF = MU_ONE / 2;

   // ramp distances are below 15 units; ramp value = delta * MU_ONE / span
   localparam int DIST_W   = FRAC_BITS + 4;
   localparam int NUMR_W   = DIST_W + MU_FRAC;
   localparam int RECIP_SH = NUMR_W + FRAC_BITS + 4;
   localparam int RECIP_W  = RECIP_SH - FRAC_BITS;
   localparam int PROD_W   = NUMR_W + RECIP_W;

   localparam longint unsigned RCP_BASE = longint'(1) << RECIP_SH;
   localparam longint unsigned RCP_COLD = (RCP_BASE + 4 * ONE - 1) / (4 * ONE);
   localparam longint unsigned RCP_COMF = (RCP_BASE + 2 * ONE - 1) / (2 * ONE);
   localparam longint unsigned RCP_HOT  = (RCP_BASE + 4 * ONE - 1) / (4 * ONE);
   localparam longint unsigned RCP_LOW  = (RCP_BASE + 10 * ONE - 1) / (10 * ONE);
   localparam longint unsigned RCP_RISE = (RCP_BASE + 5 * ONE - 1) / (5 * ONE);
   localparam longint unsigned RCP_FALL = (RCP_BASE + 10 * ONE - 1) / (10 * ONE);
   localparam longint unsigned RCP_HIGH = (RCP_BASE + 15 * ONE - 1) / (15 * ONE);

   // output singletons
   localparam int SGL_LOW  = 64;
   localparam int SGL_MED  = 160;
   localparam int SGL_HIGH = 255;

   // comfort score
   localparam int SCORE_MAX    = 100;
   localparam int PEN_TEMP     = 30;
   localparam int PEN_NH3      = 40;
   localparam int PEN_NH3_HI   = 20;
   localparam int PEN_HUM      = 10;
   localparam int PEN_HIGH_NH3 = 15;
   localparam int HUM_LO       = 40 * ONE;
   localparam int HUM_HI       = 80 * ONE;

   // back end words
   localparam int SUM_W  = MU_W + 1;
   localparam int NUM_W  = SUM_W + SPEED_W - 1;
   localparam int QUO_W  = SPEED_W;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      MU_ZERO,
      MU_FULL,
      MU_RAMP
   } mu_kind_type;

   typedef struct packed {
      mu_kind_type       kind;
      logic [DIST_W-1:0] delta;
   } ramp_type;

   // front to back word: centroid numerator and denominator plus score
   typedef struct packed {
      logic [NUM_W-1:0]   numer;
      logic [SUM_W-1:0]   total;
      logic [SCORE_W-1:0] score;
   } fzy_work_type;

   // one divider stage
   typedef struct packed {
      logic [NUM_W-1:0]   rem;
      logic [SUM_W-1:0]   total;
      logic [QUO_W-1:0]   quo;
      logic [SCORE_W-1:0] score;
   } fzy_div_type;

   function automatic ramp_type mk_ramp(mu_kind_type kind, int delta);
      ramp_type r;
      r.kind  = kind;
      r.delta = (kind == MU_RAMP) ? DIST_W'(delta) : '0;
      return r;
   endfunction

   // floor(delta * MU_ONE / span) through the reciprocal of span
   function automatic logic [MU_W-1:0] eval_mu(ramp_type r, logic [RECIP_W-1:0] recip);
      logic [NUMR_W-1:0] x;
      logic [PROD_W-1:0] p;
      logic [MU_W-1:0]   mu;
      x = {r.delta, MU_FRAC'(0)};
      p = PROD_W'(x) * PROD_W'(recip);
      case (r.kind)
         MU_FULL: mu = MU_W'(MU_ONE);
         MU_RAMP: mu = p[RECIP_SH +: MU_W];
         default: mu = '0;
      endcase
      return mu;
   endfunction

   function automatic logic [MU_W-1:0] mu_min(logic [MU_W-1:0] a, logic [MU_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [MU_W-1:0] mu_max(logic [MU_W-1:0] a, logic [MU_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== design/fzy_if.sv =====
interface fzy_req_if import fzy_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature;
   logic [HUM_W-1:0]         humidity;
   logic [NH3_W-1:0]         ammonia;

   modport source (output valid, temperature, humidity, ammonia, input ready);
   modport sink (input valid, temperature, humidity, ammonia, output ready);
endinterface

interface fzy_rsp_if import fzy_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] fan_speed;
   logic [SCORE_W-1:0] comfort_score;

   modport source (output valid, fan_speed, comfort_score, input ready);
   modport sink (input valid, fan_speed, comfort_score, output ready);
endinterface

// ===== design/fzy_front.sv =====
module fzy_front import fzy_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [TGT_W-1:0] csr_wr_data,
   fzy_req_if.sink      req_bus,
   output logic         out_valid,
   input  logic         out_ready,
   output fzy_work_type out_work
);

   typedef struct packed {
      ramp_type           cold;
      ramp_type           comf;
      ramp_type           hot;
      ramp_type           low;
      ramp_type           med;
      logic               med_fall;
      ramp_type           high;
      logic [SCORE_W-1:0] score;
   } fzy_class_type;

   typedef struct packed {
      logic [MU_W-1:0]    cold;
      logic [MU_W-1:0]    comf;
      logic [MU_W-1:0]    hot;
      logic [MU_W-1:0]    low;
      logic [MU_W-1:0]    med;
      logic [MU_W-1:0]    high;
      logic [SCORE_W-1:0] score;
   } fzy_mu_type;

   logic [TGT_W-1:0] target_ff;
   logic             v1_ff, v2_ff, v3_ff;
   logic             rdy1, rdy2, rdy3;
   fzy_class_type    s1_in, s1_ff;
   fzy_mu_type       s2_in, s2_ff;
   fzy_work_type     s3_in, s3_ff;

   assign rdy3 = !v3_ff || out_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_bus.ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
      end else if (csr_wr_en) begin
         target_ff <= csr_wr_data;
      end
   end

   // stage 1: error, ramp segment and distance, penalties
   always_comb begin
      int e, m, a, h, pen;
      e = int'(req_bus.temperature) - int'(target_ff);
      m = (e < 0) ? -e : e;
      a = int'(req_bus.ammonia);
      h = int'(req_bus.humidity);

      if (e <= -5 * ONE)     s1_in.cold = mk_ramp(MU_FULL, 0);
      else if (e >= -ONE)    s1_in.cold = mk_ramp(MU_ZERO, 0);
      else                   s1_in.cold = mk_ramp(MU_RAMP, -e - ONE);

      if (m >= 3 * ONE)      s1_in.comf = mk_ramp(MU_ZERO, 0);
      else if (m <= ONE)     s1_in.comf = mk_ramp(MU_FULL, 0);
      else                   s1_in.comf = mk_ramp(MU_RAMP, 3 * ONE - m);

      if (e >= 5 * ONE)      s1_in.hot = mk_ramp(MU_FULL, 0);
      else if (e <= ONE)     s1_in.hot = mk_ramp(MU_ZERO, 0);
      else                   s1_in.hot = mk_ramp(MU_RAMP, e - ONE);

      if (a <= 10 * ONE)     s1_in.low = mk_ramp(MU_FULL, 0);
      else if (a >= 20 * ONE) s1_in.low = mk_ramp(MU_ZERO, 0);
      else                   s1_in.low = mk_ramp(MU_RAMP, 20 * ONE - a);

      s1_in.med_fall = 1'b0;
      if (a <= 10 * ONE || a >= 45 * ONE) begin
         s1_in.med = mk_ramp(MU_ZERO, 0);
      end else if (a >= 15 * ONE && a <= 35 * ONE) begin
         s1_in.med = mk_ramp(MU_FULL, 0);
      end else if (a < 15 * ONE) begin
         s1_in.med = mk_ramp(MU_RAMP, a - 10 * ONE);
      end else begin
         s1_in.med = mk_ramp(MU_RAMP, 45 * ONE - a);
         s1_in.med_fall = 1'b1;
      end

      if (a >= 50 * ONE)     s1_in.high = mk_ramp(MU_FULL, 0);
      else if (a <= 35 * ONE) s1_in.high = mk_ramp(MU_ZERO, 0);
      else                   s1_in.high = mk_ramp(MU_RAMP, a - 35 * ONE);

      // penalties add to at most the full score, so no clamp here
      pen = 0;
      if (m > 3 * ONE) pen = pen + PEN_TEMP;
      if (a > 25 * ONE) pen = pen + PEN_NH3;
      if (a > 50 * ONE) pen = pen + PEN_NH3_HI;
      if (h < HUM_LO || h > HUM_HI) pen = pen + PEN_HUM;
      s1_in.score = SCORE_W'(SCORE_MAX - pen);
   end

   // stage 2: ramp values
   always_comb begin
      s2_in.cold  = eval_mu(s1_ff.cold, RECIP_W'(RCP_COLD));
      s2_in.comf  = eval_mu(s1_ff.comf, RECIP_W'(RCP_COMF));
      s2_in.hot   = eval_mu(s1_ff.hot, RECIP_W'(RCP_HOT));
      s2_in.low   = eval_mu(s1_ff.low, RECIP_W'(RCP_LOW));
      s2_in.med   = eval_mu(s1_ff.med,
                            s1_ff.med_fall ? RECIP_W'(RCP_FALL) : RECIP_W'(RCP_RISE));
      s2_in.high  = eval_mu(s1_ff.high, RECIP_W'(RCP_HIGH));
      s2_in.score = s1_ff.score;
   end

   // stage 3: rule base, centroid terms, ammonia score cut
   always_comb begin
      logic [MU_W-1:0] fl, fm, fh;
      fl = mu_max(mu_max(mu_min(s2_ff.cold, s2_ff.low), mu_min(s2_ff.cold, s2_ff.med)),
                  mu_min(s2_ff.comf, s2_ff.low));
      fm = mu_max(mu_max(mu_min(s2_ff.cold, s2_ff.high), mu_min(s2_ff.comf, s2_ff.med)),
                  mu_min(s2_ff.hot, s2_ff.low));
      fh = mu_max(mu_max(mu_min(s2_ff.comf, s2_ff.high), mu_min(s2_ff.hot, s2_ff.med)),
                  mu_min(s2_ff.hot, s2_ff.high));
      s3_in.total = SUM_W'(fl) + SUM_W'(fm) + SUM_W'(fh);
      s3_in.numer = NUM_W'(fl) * NUM_W'(SGL_LOW) + NUM_W'(fm) * NUM_W'(SGL_MED)
                  + NUM_W'(fh) * NUM_W'(SGL_HIGH);
      if (s2_ff.high > MU_W'(MU_HALF)) begin
         s3_in.score = (s2_ff.score > SCORE_W'(PEN_HIGH_NH3))
                     ? s2_ff.score - SCORE_W'(PEN_HIGH_NH3) : '0;
      end else begin
         s3_in.score = s2_ff.score;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_bus.valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_bus.valid) s1_ff <= s1_in;
      if (rdy2 && v1_ff) s2_ff <= s2_in;
      if (rdy3 && v2_ff) s3_ff <= s3_in;
   end

   assign out_valid = v3_ff;
   assign out_work  = s3_ff;

endmodule

// ===== design/fzy_fifo.sv =====
module fzy_fifo import fzy_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  fzy_work_type in_work,
   output logic         out_valid,
   input  logic         out_ready,
   output fzy_work_type out_work
);

   fzy_work_type          mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, rd_ff;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  push, pop;

   assign in_ready  = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_work  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + FIFO_CNT_W'(1);
      else if (pop && !push) count_in = count_ff - FIFO_CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ff <= wr_ff + FIFO_PTR_W'(1);
         if (pop) rd_ff <= rd_ff + FIFO_PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_work;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + FIFO_CNT_W'(1))
      else $error("queue count missed a push");

endmodule

// ===== design/fzy_divider.sv =====
module fzy_divider import fzy_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  fzy_work_type in_work,
   fzy_rsp_if.source    rsp_bus
);

   localparam int LAST = QUO_W - 1;

   fzy_div_type stg_ff [QUO_W];
   logic        valid_ff [QUO_W];
   fzy_div_type src [QUO_W];
   logic        src_v [QUO_W];
   logic [QUO_W:0] rdy;

   assign rdy[QUO_W] = rsp_bus.ready;
   assign in_ready   = rdy[0];

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;
      fzy_div_type      stg_in;
      logic [NUM_W-1:0] trial;

      assign rdy[k] = !valid_ff[k] || rdy[k+1];

      if (k == 0) begin : g_head
         assign src_v[k] = in_valid;
         assign src[k]   = {in_work.numer, in_work.total, QUO_W'(0), in_work.score};
      end else begin : g_body
         assign src_v[k] = valid_ff[k-1];
         assign src[k]   = stg_ff[k-1];
      end

      assign trial = NUM_W'(src[k].total) << BIT;

      always_comb begin
         stg_in = src[k];
         if (src[k].rem >= trial) begin
            stg_in.rem      = src[k].rem - trial;
            stg_in.quo[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= src_v[k];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k] && src_v[k]) stg_ff[k] <= stg_in;
      end
   end

   // no fired rule: fan off
   assign rsp_bus.valid         = valid_ff[LAST];
   assign rsp_bus.fan_speed     = (stg_ff[LAST].total == '0) ? '0 : stg_ff[LAST].quo;
   assign rsp_bus.comfort_score = stg_ff[LAST].score;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && stg_ff[LAST].total != '0
      |-> stg_ff[LAST].rem < NUM_W'(stg_ff[LAST].total))
      else $error("divider remainder not reduced");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAST] && !rsp_bus.ready |=> valid_ff[LAST] && $stable(stg_ff[LAST]))
      else $error("output stage changed while stalled");

endmodule

// ===== design/fuzzy_fan_speed_controller_core.sv =====
// Fuzzy fan speed controller.
// req_bus carries one sensor word: temperature (signed), humidity and ammonia,
// all with FRAC_BITS fraction bits. rsp_bus returns one word per request:
// fan_speed (0..255) and comfort_score (0..100), in request order.
// csr_wr_en/csr_wr_data load the target temperature; write only while idle.
// From request accept to rsp_bus.valid a word passes front stage 1 (loaded
// at the accept edge), then 2 more front stages, the queue and 8 divider
// stages.
// Throughput: one word per cycle while rsp_bus does not stall; the divider
// resolves one quotient bit per stage, so a word enters every cycle.
// A 4-entry queue sits between the rule evaluation front and the divider;
// a stall on rsp_bus backs up the divider, then the queue, then the front,
// and req_bus.ready drops only once all of them hold a word.
// Reset is synchronous: all pipeline words are dropped, the queue empties and
// the target returns to 33 degrees. No words are lost or repeated under stall.
module fuzzy_fan_speed_controller_core import fzy_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [TGT_W-1:0] csr_wr_data,
   fzy_req_if.sink          req_bus,
   fzy_rsp_if.source        rsp_bus
);

   logic         front_valid, front_ready;
   fzy_work_type front_work;
   logic         queue_valid, queue_ready;
   fzy_work_type queue_work;

   fzy_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .out_valid   (front_valid),
      .out_ready   (front_ready),
      .out_work    (front_work)
   );

   fzy_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_work   (front_work),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_work  (queue_work)
   );

   fzy_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .in_valid (queue_valid),
      .in_ready (queue_ready),
      .in_work  (queue_work),
      .rsp_bus  (rsp_bus)
   );

endmodule

// ===== tb/fzy_checker.sv =====
module fzy_checker import fzy_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [TGT_W-1:0] csr_wr_data,
   fzy_req_if               req_mon,
   fzy_rsp_if               rsp_mon,
   input  logic             run_done,
   output int               words_due,
   output int               mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic [SCORE_W-1:0] score;
   } fan_word_type;

   fan_word_type     fan_words_due [$];
   logic [TGT_W-1:0] target_copy = TARGET_RESET;
   logic             leftover_flagged = 1'b0;

   initial begin
      words_due  = 0;
      mismatches = 0;
   end

   function automatic int fmin(int a, int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int fmax(int a, int b);
      return (a > b) ? a : b;
   endfunction

   // floored ramp value; delta and span are never negative here
   function automatic int ramp(int delta, int span);
      return (delta * MU_ONE) / span;
   endfunction

   function automatic fan_word_type fuzzy_fan_output(logic signed [TEMP_W-1:0] temp,
                                                     logic [HUM_W-1:0] hum,
                                                     logic [NH3_W-1:0] nh3,
                                                     logic [TGT_W-1:0] target);
      int err, mag, a, h;
      int cold, comf, hot, lo, md, hi;
      int f_lo, f_md, f_hi, total, speed, pen, score;
      fan_word_type w;
      err = int'(temp) - int'(target);
      mag = (err < 0) ? -err : err;
      a   = int'(nh3);
      h   = int'(hum);

      if (err <= -5 * ONE)     cold = MU_ONE;
      else if (err >= -ONE)    cold = 0;
      else                     cold = ramp(-err - ONE, 4 * ONE);

      if (mag >= 3 * ONE)      comf = 0;
      else if (mag <= ONE)     comf = MU_ONE;
      else                     comf = ramp(3 * ONE - mag, 2 * ONE);

      if (err >= 5 * ONE)      hot = MU_ONE;
      else if (err <= ONE)     hot = 0;
      else                     hot = ramp(err - ONE, 4 * ONE);

      if (a <= 10 * ONE)       lo = MU_ONE;
      else if (a >= 20 * ONE)  lo = 0;
      else                     lo = ramp(20 * ONE - a, 10 * ONE);

      if (a <= 10 * ONE || a >= 45 * ONE) md = 0;
      else if (a >= 15 * ONE && a <= 35 * ONE) md = MU_ONE;
      else if (a < 15 * ONE)   md = ramp(a - 10 * ONE, 5 * ONE);
      else                     md = ramp(45 * ONE - a, 10 * ONE);

      if (a >= 50 * ONE)       hi = MU_ONE;
      else if (a <= 35 * ONE)  hi = 0;
      else                     hi = ramp(a - 35 * ONE, 15 * ONE);

      f_lo = fmax(fmax(fmin(cold, lo), fmin(cold, md)), fmin(comf, lo));
      f_md = fmax(fmax(fmin(cold, hi), fmin(comf, md)), fmin(hot, lo));
      f_hi = fmax(fmax(fmin(comf, hi), fmin(hot, md)), fmin(hot, hi));

      total = f_lo + f_md + f_hi;
      if (total <= 0) begin
         speed = 0;
      end else begin
         speed = (f_lo * 64 + f_md * 160 + f_hi * 255) / total;
         if (speed > 255) speed = 255;
      end

      pen = 0;
      if (mag > 3 * ONE) pen += 30;
      if (a > 25 * ONE) pen += 40;
      if (a > 50 * ONE) pen += 20;
      if (h < 40 * ONE || h > 80 * ONE) pen += 10;
      score = fmax(100 - pen, 0);
      // extra cut once high-ammonia membership passes one half
      if (hi > MU_ONE / 2) score = fmax(score - 15, 0);

      w.speed = SPEED_W'(speed);
      w.score = SCORE_W'(score);
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      fan_word_type want;
      if (reset) begin
         target_copy = TARGET_RESET;
         fan_words_due.delete();
      end else begin
         if (csr_wr_en)
            target_copy = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            fan_words_due.push_back(fuzzy_fan_output(req_mon.temperature, req_mon.humidity,
                                                     req_mon.ammonia, target_copy));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (fan_words_due.size() == 0) begin
               report_mismatch($sformatf("result word with none expected: speed %0d score %0d",
                                         rsp_mon.fan_speed, rsp_mon.comfort_score));
            end else begin
               want = fan_words_due.pop_front();
               if (rsp_mon.fan_speed !== want.speed)
                  report_mismatch($sformatf("fan_speed %0d, expected %0d",
                                            rsp_mon.fan_speed, want.speed));
               if (rsp_mon.comfort_score !== want.score)
                  report_mismatch($sformatf("comfort_score %0d, expected %0d",
                                            rsp_mon.comfort_score, want.score));
            end
         end
         if (run_done && !leftover_flagged && fan_words_due.size() != 0) begin
            leftover_flagged = 1'b1;
            report_mismatch($sformatf("%0d result words never arrived", fan_words_due.size()));
         end
      end
      words_due = fan_words_due.size();
   end

endmodule

// ===== tb/fuzzy_fan_speed_controller_core_tb.sv =====
module fuzzy_fan_speed_controller_core_tb import fzy_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 11;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 108;
   localparam int DIRECTED    = 24;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_wr_en;
   logic [TGT_W-1:0] csr_wr_data;
   logic             run_done;
   logic             req_took = 1'b0;
   int               words_due;
   int               mismatches;
   int               quiet_cycles = 0;
   int               req_idle_pct = 16;
   int               rsp_idle_pct = 73;
   int               target_now = 528;

   // target 528: error steps around every ramp knee
   int dir_temp [DIRECTED] = '{-2048, 2047, 448, 464, 480, 488, 500, 512, 520, 528, 536, 544,
                               560, 576, 592, 608, 1360, -640, 0, 440, 616, 504, 552, 528};
   int dir_nh3  [DIRECTED] = '{0, 8191, 160, 161, 200, 240, 320, 400, 401, 560, 561, 640,
                               720, 721, 800, 801, 4096, 100, 300, 480, 600, 700, 780, 1000};
   int dir_hum  [8]        = '{0, 639, 640, 1280, 1281, 2047, 1600, 800};
   int phase_target [PHASES] = '{0, 1023, 800, -1, 1, 528};

   fzy_req_if req ();
   fzy_rsp_if rsp ();

   fuzzy_fan_speed_controller_core uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req),
      .rsp_bus     (rsp)
   );

   fzy_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mon     (req),
      .rsp_mon     (rsp),
      .run_done    (run_done),
      .words_due   (words_due),
      .mismatches  (mismatches)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      req_took <= req.valid && req.ready;
   end

   // watchdog: too long without a word moving on either channel
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic send_sample(input int t, input int h, input int a);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < req_idle_pct) @(negedge clock);
      end
      req.valid       <= 1'b1;
      req.temperature <= TEMP_W'(t);
      req.humidity    <= HUM_W'(h);
      req.ammonia     <= NH3_W'(a);
      @(negedge clock);
      while (!req_took) @(negedge clock);
   endtask

   // hold off until every expected word is back, then let the pipe settle
   task automatic drain_results;
      req.valid <= 1'b0;
      while (words_due != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_target(input int value);
      csr_wr_data <= TGT_W'(value);
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      target_now = value;
   endtask

   initial begin
      int t, h, a, pick, tgt;
      reset           = 1'b1;
      run_done        = 1'b0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req.valid       = 1'b0;
      req.temperature = '0;
      req.humidity    = '0;
      req.ammonia     = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words at the reset target
      for (int i = 0; i < DIRECTED; i++)
         send_sample(dir_temp[i], dir_hum[i % 8], dir_nh3[i]);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         tgt = (phase_target[phase] < 0) ? int'($urandom_range(0, 1023)) : phase_target[phase];
         write_target(tgt);
         case (phase / 2)
            0: begin
               req_idle_pct = 16;
               rsp_idle_pct = 73;
            end
            1: begin
               req_idle_pct = 73;
               rsp_idle_pct = 16;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
               t = target_now + int'($urandom_range(0, 200)) - 100;
            else if (pick < 8)
               t = int'($urandom_range(0, 2000)) - 640;
            else
               t = int'($urandom_range(0, 4095)) - 2048;
            pick = $urandom_range(0, 9);
            if (pick < 7)
               a = $urandom_range(0, 60 * ONE);
            else
               a = $urandom_range(0, 8191);
            pick = $urandom_range(0, 3);
            if (pick < 3)
               h = $urandom_range(0, 1600);
            else
               h = $urandom_range(0, 2047);
            send_sample(t, h, a);
         end
      end

      drain_results();
      run_done <= 1'b1;
      repeat (2) @(negedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
